@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/mfcs_pkg.sv @@
// Types and constants of the frame cluster synchroniser
package mfcs_pkg;
    localparam int MaxStreams = 8;
    localparam int SidW = $clog2(MaxStreams);
    localparam int CntW = $clog2(MaxStreams + 1);
    localparam int MaskW = 8;
    localparam logic [0:0] REQ_FRAME = 1'b0;
    localparam logic [0:0] REQ_EVAL = 1'b1;
    localparam logic [1:0] CFG_COUNT = 2'd0;
    localparam logic [1:0] CFG_PERIOD = 2'd1;
    localparam logic [1:0] CFG_STALE = 2'd2;
    localparam logic [1:0] CFG_WINDOW = 2'd3;
    localparam logic [3:0] RST_COUNT = 4'd1;
    localparam logic [31:0] RST_PERIOD = 32'd35000000;
    localparam logic [31:0] RST_STALE = 32'd400000000;
    localparam logic [31:0] RST_WINDOW = 32'd500000000;

    typedef struct packed {
        logic [0:0] req_type;
        logic [2:0] stream_id;
        logic [63:0] frame_time;
        logic [63:0] wall_time;
    } t_in;

    typedef struct packed {
        logic [63:0] cluster_time;
        logic [7:0] stream_mask;
    } t_out;

    typedef struct packed {
        logic [1:0] index;
        logic [31:0] data;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE, S_SORT, S_STALE, S_ACTIVE, S_GAP, S_HOLD, S_WIN, S_MASK, S_OUT
    } t_state;

    // operations of the shared 64-bit unit
    typedef enum logic [1:0] { OP_ADD, OP_SUB } t_op;

    typedef struct packed {
        t_op op;
        logic [63:0] a;
        logic [63:0] b;
    } t_alu_req;
endpackage

@@ hw/rtl/mfcs_if.sv @@
// Valid/ready channel interfaces
interface mfcs_in_if (input logic i_clk);
    import mfcs_pkg::*;
    logic valid;
    logic ready;
    t_in data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mfcs_out_if (input logic i_clk);
    import mfcs_pkg::*;
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mfcs_cfg_if (input logic i_clk);
    import mfcs_pkg::*;
    logic valid;
    logic ready;
    t_cfg data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/mfcs_alu.sv @@
// Shared 64-bit add/subtract unit with a greater-than compare flag
module mfcs_alu (
    input  mfcs_pkg::t_alu_req i_req,
    output logic [63:0]        o_res,
    output logic               o_a_gt_b
);
    import mfcs_pkg::*;
    always_comb begin
        case (i_req.op)
            OP_ADD:  o_res = i_req.a + i_req.b;
            OP_SUB:  o_res = i_req.a - i_req.b;
            default: o_res = i_req.a + i_req.b;
        endcase
    end
    assign o_a_gt_b = i_req.a > i_req.b;
endmodule

@@ hw/rtl/multi_stream_frame_cluster_sync.sv @@
// Multi-stream frame cluster synchroniser, top level.
// A frame transfer is registered and its stamp stored from the idle state. An
// evaluate transfer that finds the block armed walks a sequencer around one
// shared 64-bit adder/comparator: an exchange sort taking one compare per cycle,
// then the stale and active scans together, the gap scan with one set-up step
// plus two steps per stream, the hold-off and window checks, a mask pass and a
// step to load the result; an unarmed evaluate, or one that fails the gap and
// hold-off check, ends with no result. The input is not ready while an item is
// at work. A finished result sits in the output register while the next item
// runs; the sequencer holds at its last step only while an earlier result is
// still unread.
`include "assert_macros.svh"
module multi_stream_frame_cluster_sync (
    input  logic i_clk,
    input  logic i_rst_n,
    mfcs_in_if.sink    i_in,
    mfcs_out_if.source o_out,
    mfcs_cfg_if.sink   i_cfg
);
    import mfcs_pkg::*;

    logic [3:0]  r_count;
    logic [31:0] r_period, r_stale, r_window;
    logic [63:0] r_stamp [MaxStreams];
    logic [MaxStreams-1:0] r_holds;
    logic [63:0] r_prev, r_wake;
    logic        r_ready;

    t_state r_st, n_st;
    logic [SidW-1:0] r_ord [MaxStreams];
    logic [SidW-1:0] r_i, r_j;       // scan indices
    logic [SidW-1:0] r_fv;           // first valid position
    logic [63:0] r_top, r_gtop, r_gap, r_wall, r_tmp;
    logic [1:0]  r_sub;              // sub-step inside a phase
    logic [MaskW-1:0] r_mask;
    t_in r_req;
    logic r_busy;
    logic r_ov;
    t_out r_out;

    // live stream count
    logic [CntW-1:0] live;
    always_comb begin
        if (r_count == 4'd0) live = CntW'(1);
        else if (int'(r_count) > MaxStreams) live = CntW'(MaxStreams);
        else live = CntW'(r_count);
    end
    logic [SidW-1:0] last;
    assign last = SidW'(live - CntW'(1));

    t_alu_req alu_req;
    logic [63:0] alu_res;
    logic alu_gt;
    mfcs_alu u_alu (.i_req(alu_req), .o_res(alu_res), .o_a_gt_b(alu_gt));

    // output register free to take a new result this cycle
    logic out_free;
    assign out_free = !r_ov || o_out.ready;

    assign i_in.ready = !r_busy;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_ov;
    assign o_out.data = r_out;

    logic acc;
    assign acc = i_in.valid && i_in.ready;

    logic [63:0] si, sj;
    assign si = r_stamp[r_ord[r_i]];
    assign sj = r_stamp[r_ord[r_j]];
    logic [63:0] half;
    assign half = {33'd0, r_period[31:1]};

    // time since first wake-up beyond one period
    logic late;
    assign late = alu_res > {32'd0, r_period};

    // shared unit operand selection
    always_comb begin
        alu_req = '{op: OP_SUB, a: 64'd0, b: 64'd0};
        case (r_st)
            S_IDLE:   alu_req = '{op: OP_SUB, a: r_req.wall_time, b: r_wake};
            S_SORT:   alu_req = '{op: OP_SUB, a: si, b: sj};
            S_STALE:  alu_req = '{op: OP_ADD, a: si, b: {32'd0, r_stale}};
            S_ACTIVE: alu_req = '{op: OP_ADD, a: si, b: {32'd0, r_period}};
            S_GAP: begin
                if (r_sub == 2'd0) alu_req = '{op: OP_SUB, a: r_top, b: si};
                else if (r_sub == 2'd1)
                    alu_req = '{op: OP_ADD, a: si, b: {32'd0, r_period}};
                else alu_req = '{op: OP_SUB, a: r_tmp, b: sj};
            end
            S_HOLD:   alu_req = '{op: OP_SUB, a: r_top, b: r_prev};
            S_WIN:    alu_req = '{op: OP_SUB, a: r_top, b: r_wall};
            default:  alu_req = '{op: OP_SUB, a: 64'd0, b: 64'd0};
        endcase
    end

    // window check on the difference
    logic [63:0] neg;
    logic outside;
    assign neg = 64'd0 - alu_res;
    assign outside = alu_res[63] ? (neg > {32'd0, r_window})
                                 : (alu_res > {32'd0, r_window});

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE:   if (r_busy) n_st = S_SORT;
            S_SORT:   if (last == '0 || (r_i == last - SidW'(1) && r_j == last)) n_st = S_STALE;
            S_STALE:  if (r_i == last || !(alu_res < r_top)) n_st = S_ACTIVE;
            S_ACTIVE: if (r_i == last || !(alu_res < r_top)) n_st = S_GAP;
            S_GAP:    if (r_sub != 2'd0 && (r_i == last ||
                          (r_sub == 2'd2 && alu_res < r_gtop))) n_st = S_HOLD;
            S_HOLD:   n_st = (r_gap >= r_gtop && alu_res > half) ? S_WIN : S_IDLE;
            S_WIN:    n_st = S_MASK;
            S_MASK:   if (r_i == last) n_st = S_OUT;
            S_OUT:    if (out_free) n_st = S_IDLE;
            default:  n_st = S_IDLE;
        endcase
        if (r_st == S_IDLE && r_busy && !(r_req.req_type == REQ_EVAL &&
            (r_ready || late))) n_st = S_IDLE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_busy <= 1'b0;
            r_ov <= 1'b0;
            r_count <= RST_COUNT;
            r_period <= RST_PERIOD;
            r_stale <= RST_STALE;
            r_window <= RST_WINDOW;
            r_holds <= '0;
            r_prev <= '1;
            r_wake <= '0;
            r_ready <= 1'b0;
            for (int k = 0; k < MaxStreams; k++) r_stamp[k] <= '0;
        end else begin
            r_st <= n_st;
            // result loaded as the previous one leaves, or held until read
            if (r_st == S_OUT && out_free) r_ov <= 1'b1;
            else if (o_out.valid && o_out.ready) r_ov <= 1'b0;
            if (i_cfg.valid) begin
                case (i_cfg.data.index)
                    CFG_COUNT:  r_count <= i_cfg.data.data[3:0];
                    CFG_PERIOD: r_period <= i_cfg.data.data;
                    CFG_STALE:  r_stale <= i_cfg.data.data;
                    CFG_WINDOW: r_window <= i_cfg.data.data;
                    default: ;
                endcase
            end
            if (acc) begin
                r_req <= i_in.data;
                r_busy <= 1'b1;
            end
            case (r_st)
                S_IDLE: if (r_busy) begin
                    if (r_req.req_type == REQ_FRAME) begin
                        r_busy <= 1'b0;
                        if (CntW'(r_req.stream_id) < live) begin
                            if (r_wake == 64'd0) r_wake <= r_req.wall_time;
                            if (r_stamp[r_req.stream_id] != 64'd0) r_ready <= 1'b1;
                            r_stamp[r_req.stream_id] <= r_req.frame_time;
                            r_holds[r_req.stream_id] <= 1'b1;
                        end
                    end else begin
                        if (late) r_ready <= 1'b1;
                        if (!(r_ready || late)) r_busy <= 1'b0;
                        r_wall <= r_req.wall_time;
                        for (int k = 0; k < MaxStreams; k++) r_ord[k] <= SidW'(k);
                        r_i <= '0;
                        r_j <= SidW'(1);
                    end
                end
                S_SORT: begin
                    if (last != '0 && alu_gt && !alu_res[63] | alu_gt) begin
                        r_ord[r_i] <= r_ord[r_j];
                        r_ord[r_j] <= r_ord[r_i];
                    end
                    if (r_j == last) begin
                        r_i <= r_i + SidW'(1);
                        r_j <= r_i + SidW'(2);
                    end else r_j <= r_j + SidW'(1);
                    if (n_st == S_STALE) begin
                        r_i <= '0;
                        r_top <= (last != '0 && r_i == last - SidW'(1) && alu_gt)
                            ? si : r_stamp[r_ord[last]];
                    end
                end
                S_STALE: begin
                    if (n_st == S_STALE) r_i <= r_i + SidW'(1);
                    else r_fv <= r_i;
                end
                S_ACTIVE: begin
                    if (n_st == S_ACTIVE) r_i <= r_i + SidW'(1);
                    r_sub <= 2'd0;
                end
                S_GAP: begin
                    r_j <= r_i + SidW'(1);
                    case (r_sub)
                        2'd0: begin
                            r_gtop <= alu_res;
                            r_gap <= alu_res;
                            r_sub <= 2'd1;
                        end
                        2'd1: begin
                            r_tmp <= alu_res;
                            r_sub <= 2'd2;
                        end
                        default: begin
                            r_gap <= alu_res;
                            r_sub <= 2'd1;
                            if (!(alu_res < r_gtop)) r_i <= r_i + SidW'(1);
                        end
                    endcase
                end
                S_HOLD: begin
                    if (n_st == S_IDLE) r_busy <= 1'b0;
                end
                S_WIN: begin
                    if (outside) r_top <= r_wall;
                    r_i <= '0;
                    r_mask <= '0;
                end
                S_MASK: begin
                    if (r_i >= r_fv && r_holds[r_ord[r_i]] && 32'(r_ord[r_i]) < MaskW)
                        r_mask[r_ord[r_i][2:0]] <= 1'b1;
                    if (r_i != last) r_i <= r_i + SidW'(1);
                end
                S_OUT: if (out_free) begin
                    r_prev <= r_top;
                    r_out.cluster_time <= r_top;
                    r_out.stream_mask <= r_mask;
                    r_busy <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    `ASSERT_IMPLIES(a_no_acc_busy, i_clk, i_rst_n, r_busy, !i_in.ready)
    `ASSERT_NEXT(a_out_from_seq, i_clk, i_rst_n, !r_ov && !(r_st == S_OUT), !r_ov)
    `ASSERT_NEXT(a_idle_after_out, i_clk, i_rst_n, r_st == S_OUT && out_free, r_st == S_IDLE && !r_busy)
endmodule

@@ tb/sv/multi_stream_frame_cluster_sync_tb.sv @@
// Self-checking testbench of the multi-stream frame cluster synchroniser
`timescale 1ns / 100ps
module multi_stream_frame_cluster_sync_tb;
    import mfcs_pkg::*;

    localparam int CycleLimit = 1000000;
    localparam int DrainCycles = 100;

    logic i_clk;
    logic i_rst_n;

    mfcs_in_if  in_if (i_clk);
    mfcs_out_if out_if (i_clk);
    mfcs_cfg_if cfg_if (i_clk);

    multi_stream_frame_cluster_sync dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Transfers waiting to be driven, and cluster releases still owed by the block
    t_in  frame_queue[$];
    t_out release_queue[$];

    int   fail_count;
    int   cycle_count;
    bit   steady;        // no idling on either side while set

    // Shadow copy of the block's state and registers
    logic [63:0] stamp_of[MaxStreams];
    bit          has_frame[MaxStreams];
    logic [63:0] last_cluster;
    logic [63:0] wake_time;
    bit          armed;
    logic [3:0]  cnt_reg;
    logic [31:0] period_reg;
    logic [31:0] stale_reg;
    logic [31:0] window_reg;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h, want %h at cycle %0d", what, got, want, cycle_count);
        fail_count++;
    endtask

    function automatic int live_count();
        int n;
        n = cnt_reg;
        if (n == 0) n = 1;
        if (n > MaxStreams) n = MaxStreams;
        return n;
    endfunction

    // Works out whether a transfer releases a cluster, updating the shadow state
    function automatic bit cluster_step(input t_in it, output t_out res);
        int          order[MaxStreams];
        int          n, i, j, t, valid_from, active_from;
        logic [63:0] top, gap_top, gap, d, mag;
        bit          stop;
        res = '0;
        n = live_count();
        if (it.req_type == REQ_FRAME) begin
            if (it.stream_id >= n) return 0;
            if (wake_time == 0) wake_time = it.wall_time;
            if (stamp_of[it.stream_id] != 0) armed = 1;
            stamp_of[it.stream_id] = it.frame_time;
            has_frame[it.stream_id] = 1;
            return 0;
        end
        if (it.wall_time - wake_time > {32'd0, period_reg}) armed = 1;
        if (!armed) return 0;

        // exchange sort, ascending by stamp
        for (i = 0; i < n; i++) order[i] = i;
        for (i = 0; i + 1 < n; i++)
            for (j = i + 1; j < n; j++)
                if (stamp_of[order[i]] > stamp_of[order[j]]) begin
                    t = order[i]; order[i] = order[j]; order[j] = t;
                end

        top = stamp_of[order[n-1]];
        i = 0;
        while (i + 1 < n && stamp_of[order[i]] + {32'd0, stale_reg} < top) i++;
        valid_from = i;
        while (i + 1 < n && stamp_of[order[i]] + {32'd0, period_reg} < top) i++;
        active_from = i;

        gap_top = top - stamp_of[order[active_from]];
        gap = gap_top;
        stop = 0;
        while (!stop && i + 1 < n) begin
            gap = stamp_of[order[i]] + {32'd0, period_reg} - stamp_of[order[i+1]];
            if (gap < gap_top) stop = 1;
            else i++;
        end

        if (!(gap >= gap_top && (top - last_cluster) > {33'd0, period_reg[31:1]})) return 0;

        // signed distance from wall time beyond the window falls back to wall time
        d = top - it.wall_time;
        mag = d[63] ? (64'd0 - d) : d;
        if (mag > {32'd0, window_reg}) top = it.wall_time;
        last_cluster = top;

        res.cluster_time = top;
        for (i = 0; i < n; i++)
            if (i >= valid_from && has_frame[order[i]]) res.stream_mask[order[i]] = 1'b1;
        return 1;
    endfunction

    // Driver: next queued transfer once the previous one has gone
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_if.data  <= '0;
        end else if (!in_if.valid || in_if.ready) begin
            if (frame_queue.size() > 0 && (steady || $urandom_range(99) >= 15)) begin
                in_if.valid <= 1'b1;
                in_if.data  <= frame_queue.pop_front();
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) out_if.ready <= 1'b0;
        else out_if.ready <= steady || ($urandom_range(99) >= 15);
    end

    // Monitor: predict on each input transfer, check each output transfer
    always @(posedge i_clk) begin
        t_out want;
        t_out got;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready)
                if (cluster_step(in_if.data, want)) release_queue.push_back(want);
            if (out_if.valid && out_if.ready) begin
                got = out_if.data;
                if (release_queue.size() == 0) begin
                    report("unexpected release", got.cluster_time, 64'd0);
                end else begin
                    want = release_queue.pop_front();
                    if (got.cluster_time !== want.cluster_time)
                        report("cluster_time", got.cluster_time, want.cluster_time);
                    if (got.stream_mask !== want.stream_mask)
                        report("stream_mask", {56'd0, got.stream_mask}, {56'd0, want.stream_mask});
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("multi_stream_frame_cluster_sync test failed");
            $finish;
        end
    end

    function automatic t_in make_item(input bit is_eval, input int sid,
                                      input logic [63:0] ft, input logic [63:0] wt);
        t_in it;
        it.req_type   = is_eval ? REQ_EVAL : REQ_FRAME;
        it.stream_id  = sid[2:0];
        it.frame_time = ft;
        it.wall_time  = wt;
        return it;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Block idle: everything driven, every release seen, then the worst-case evaluate time
    task automatic settle();
        do @(posedge i_clk);
        while (frame_queue.size() > 0 || in_if.valid || release_queue.size() > 0);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        t_cfg c;
        c.index = idx;
        c.data  = val;
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= c;
        do @(posedge i_clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            CFG_COUNT:  cnt_reg    = val[3:0];
            CFG_PERIOD: period_reg = val;
            CFG_STALE:  stale_reg  = val;
            CFG_WINDOW: window_reg = val;
            default: ;
        endcase
    endtask

    // Realistic traffic: rounds of frames around a moving time base, then an evaluate
    task automatic stream_traffic(input int items);
        logic [63:0] base;
        int          k, s, n;
        base = 64'd1_000_000_000 + $urandom_range(1000);
        k = 0;
        while (k < items) begin
            n = live_count();
            if ($urandom_range(9) == 0) begin
                // noise: anything the fields allow
                frame_queue.push_back(make_item($urandom_range(1), $urandom_range(7),
                                                rand64(), rand64()));
                k++;
            end else begin
                for (s = 0; s < n; s++)
                    if ($urandom_range(7) != 0) begin
                        frame_queue.push_back(make_item(0, $urandom_range(4) == 0 ?
                            $urandom_range(7) : s, base + $urandom_range(40_000_000),
                            base + $urandom_range(5_000_000)));
                        k++;
                    end
                frame_queue.push_back(make_item(1, $urandom_range(7), rand64(),
                    $urandom_range(9) == 0 ? rand64() :
                    base + $urandom_range(60_000_000) - 20_000_000));
                k++;
            end
            // occasionally a long jump so that streams go stale
            base += $urandom_range(3) == 0 ? 64'd500_000_000 + $urandom_range(1_000_000_000)
                                           : 64'd20_000_000 + $urandom_range(20_000_000);
        end
    endtask

    initial begin
        int p;
        fail_count   = 0;
        cycle_count  = 0;
        steady       = 0;
        i_rst_n      = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        for (p = 0; p < MaxStreams; p++) begin
            stamp_of[p]  = '0;
            has_frame[p] = 0;
        end
        last_cluster = '1;
        wake_time    = '0;
        armed        = 0;
        cnt_reg      = RST_COUNT;
        period_reg   = RST_PERIOD;
        stale_reg    = RST_STALE;
        window_reg   = RST_WINDOW;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: evaluate before any frame, frames with a zero wall time,
        // unused stream, replacement raising ready, extreme field values
        frame_queue.push_back(make_item(1, 0, '1, 64'd10));
        frame_queue.push_back(make_item(0, 3, 64'd5, 64'd0));
        frame_queue.push_back(make_item(0, 0, 64'd100, 64'd0));
        frame_queue.push_back(make_item(1, 7, '0, 64'd0));
        frame_queue.push_back(make_item(0, 0, 64'd200, 64'd50));
        frame_queue.push_back(make_item(1, 0, '0, 64'd300));
        frame_queue.push_back(make_item(0, 0, '1, '1));
        frame_queue.push_back(make_item(1, 0, '1, '1));
        frame_queue.push_back(make_item(1, 0, '0, 64'h8000_0000_0000_0000));
        settle();

        write_reg(CFG_COUNT, 32'd8);
        write_reg(CFG_WINDOW, 32'd0);
        for (p = 0; p < 8; p++)
            frame_queue.push_back(make_item(0, p, 64'd1000 + 64'(p) * 7_000_000, 64'd5));
        frame_queue.push_back(make_item(1, 0, '0, 64'd40_000_000));
        frame_queue.push_back(make_item(0, 2, 64'd1000, 64'd6));
        frame_queue.push_back(make_item(1, 0, '0, 64'd90_000_000));
        frame_queue.push_back(make_item(1, 0, '0, 64'd90_000_001));
        settle();

        // Random phases across register settings, extremes included
        write_reg(CFG_WINDOW, RST_WINDOW);
        stream_traffic(250);
        settle();                       // sender holds until all releases are in
        write_reg(CFG_COUNT, 32'hFFFF_FFF0);   // count zero behaves as one
        write_reg(CFG_PERIOD, 32'd0);
        write_reg(CFG_STALE, 32'd0);
        stream_traffic(100);
        settle();
        write_reg(CFG_COUNT, 32'd15);
        write_reg(CFG_PERIOD, 32'd4_000_000_000);
        write_reg(CFG_STALE, 32'd4_000_000_000);
        write_reg(CFG_WINDOW, 32'd4_000_000_000);
        steady = 1;                     // long stretch with no idling
        stream_traffic(200);
        settle();
        steady = 0;
        write_reg(CFG_COUNT, 32'd5);
        write_reg(CFG_PERIOD, $urandom_range(50_000_000));
        write_reg(CFG_STALE, $urandom);
        write_reg(CFG_WINDOW, $urandom_range(100_000_000));
        stream_traffic(250);
        settle();
        write_reg(CFG_COUNT, 32'd8);
        write_reg(CFG_PERIOD, RST_PERIOD);
        write_reg(CFG_STALE, RST_STALE);
        write_reg(CFG_WINDOW, $urandom);
        stream_traffic(250);
        settle();
        write_reg(CFG_COUNT, 32'd3);
        write_reg(CFG_PERIOD, $urandom);
        write_reg(CFG_STALE, $urandom_range(100_000_000));
        write_reg(CFG_WINDOW, 32'd1);
        stream_traffic(250);
        settle();

        if (fail_count == 0) begin
            $display("multi_stream_frame_cluster_sync test passed");
        end else begin
            $display("multi_stream_frame_cluster_sync test failed");
        end
        $finish;
    end
endmodule
